@@ rtl/core/window_table_hit_test_unit_macros.svh @@
// Assertion macros for the window table hit test unit.
// Each check is sampled on the rising clock edge and held off during reset.
`ifndef WINDOW_TABLE_HIT_TEST_UNIT_MACROS_SVH
`define WINDOW_TABLE_HIT_TEST_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// The condition holds at every edge.
`define WTH_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("window table check failed");
// The consequent holds at every edge at which the antecedent holds.
`define WTH_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("window table check failed");
`else
`define WTH_ASSERT_ALWAYS(label, clk, rst, cond)
`define WTH_ASSERT_IMPLY(label, clk, rst, ante, cons)
`endif
`endif

@@ rtl/core/wth_pkg.sv @@
`default_nettype none

package wth_pkg;

   // Table size and the index and count widths that follow from it.
   localparam int SLOT_COUNT = 16;
   localparam int SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int TOTAL_W    = $clog2(SLOT_COUNT + 1);

   // Field widths.
   localparam int MODE_W   = 3;
   localparam int ID_W     = 32;
   localparam int PID_W    = 22;
   localparam int CLIENT_W = 6;
   localparam int POS_W    = 16;
   localparam int SIZE_W   = 15;
   localparam int STATUS_W = 2;
   localparam int LIVE_W   = 5;

   // Operation codes. Codes six and seven are not operations.
   typedef enum logic [MODE_W-1:0] {
      MODE_CREATE  = 3'd0,
      MODE_DESTROY = 3'd1,
      MODE_MOVE    = 3'd2,
      MODE_MARK    = 3'd3,
      MODE_FIND    = 3'd4,
      MODE_HIT     = 3'd5
   } mode_type;

   // Result status codes.
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK   = 2'd0,
      STATUS_FULL = 2'd1,
      STATUS_MISS = 2'd2
   } status_type;

   // One table entry.
   typedef struct packed {
      logic [ID_W-1:0]            id;
      logic [PID_W-1:0]           pid;
      logic [CLIENT_W-1:0]        client;
      logic signed [POS_W-1:0]    x;
      logic signed [POS_W-1:0]    y;
      logic [SIZE_W-1:0]          w;
      logic [SIZE_W-1:0]          h;
      logic                       committed;
   } slot_type;

   // One request as held for the length of an operation.
   typedef struct packed {
      logic [MODE_W-1:0]          mode;
      logic [ID_W-1:0]            id;
      logic [PID_W-1:0]           pid;
      logic [CLIENT_W-1:0]        client;
      logic signed [POS_W-1:0]    x;
      logic signed [POS_W-1:0]    y;
      logic [SIZE_W-1:0]          w;
      logic [SIZE_W-1:0]          h;
   } req_type;

   // Flags from the shared compare unit.
   typedef struct packed {
      logic id_match;
      logic point_in;
   } cmp_type;

endpackage

`default_nettype wire

@@ rtl/core/wth_cmp_unit.sv @@
`default_nettype none

module wth_cmp_unit (
   input  wth_pkg::req_type  req_i,
   input  wth_pkg::slot_type slot_i,
   output wth_pkg::cmp_type  cmp_o
);
   import wth_pkg::*;

   localparam int EXT_W = POS_W + 2;

   logic signed [EXT_W-1:0] px;
   logic signed [EXT_W-1:0] py;
   logic signed [EXT_W-1:0] wx;
   logic signed [EXT_W-1:0] wy;
   logic signed [EXT_W-1:0] x_end;
   logic signed [EXT_W-1:0] y_end;

   // Widen point and window corner by two sign bits so the far edge cannot overflow.
   assign px = {{2{req_i.x[POS_W-1]}}, req_i.x};
   assign py = {{2{req_i.y[POS_W-1]}}, req_i.y};
   assign wx = {{2{slot_i.x[POS_W-1]}}, slot_i.x};
   assign wy = {{2{slot_i.y[POS_W-1]}}, slot_i.y};
   assign x_end = wx + {{(EXT_W-SIZE_W){1'b0}}, slot_i.w};
   assign y_end = wy + {{(EXT_W-SIZE_W){1'b0}}, slot_i.h};

   // The far edges are exclusive.
   assign cmp_o.point_in = (px >= wx) && (px < x_end) && (py >= wy) && (py < y_end);
   assign cmp_o.id_match = (slot_i.id == req_i.id);

endmodule

`default_nettype wire

@@ rtl/core/window_table_hit_test_unit.sv @@
`default_nettype none
`include "window_table_hit_test_unit_macros.svh"
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  mode, id, pid, client, position, size
// rsp_      out        rsp_valid/rsp_stall  status, window fields, live count
//
// Each request passes from its transfer to its result through these steps: it is taken,
// each slot is read in turn from the slot memory and compared through the shared compare
// unit, the last slot is compared, and the table is written back and the result loaded.
// Reset clears all valid bits at once, sets the id counter to one and the count to zero.
// A stalled result holds the write-back step until the result register is free.

module window_table_hit_test_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [wth_pkg::MODE_W-1:0]          req_mode,
   input  logic [wth_pkg::ID_W-1:0]            req_window_id,
   input  logic [wth_pkg::PID_W-1:0]           req_owner_pid,
   input  logic [wth_pkg::CLIENT_W-1:0]        req_client_slot,
   input  logic signed [wth_pkg::POS_W-1:0]    req_pos_x,
   input  logic signed [wth_pkg::POS_W-1:0]    req_pos_y,
   input  logic [wth_pkg::SIZE_W-1:0]          req_size_w,
   input  logic [wth_pkg::SIZE_W-1:0]          req_size_h,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [wth_pkg::STATUS_W-1:0]        rsp_status,
   output logic [wth_pkg::ID_W-1:0]            rsp_found_id,
   output logic [wth_pkg::PID_W-1:0]           rsp_found_pid,
   output logic [wth_pkg::CLIENT_W-1:0]        rsp_found_client,
   output logic signed [wth_pkg::POS_W-1:0]    rsp_found_x,
   output logic signed [wth_pkg::POS_W-1:0]    rsp_found_y,
   output logic [wth_pkg::SIZE_W-1:0]          rsp_found_w,
   output logic [wth_pkg::SIZE_W-1:0]          rsp_found_h,
   output logic                                rsp_found_committed,
   output logic [wth_pkg::LIVE_W-1:0]          rsp_live_count
);
   import wth_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_LAST,
      S_WRITE
   } state_type;

   localparam logic [SLOT_IDX_W-1:0] LAST_IDX = SLOT_IDX_W'(SLOT_COUNT - 1);

   state_type               state_ff;
   req_type                 req_ff;
   slot_type                mem [SLOT_COUNT];
   slot_type                rd_ff;
   logic [SLOT_COUNT-1:0]   valid_ff;
   logic [SLOT_COUNT-1:0]   valid_in;
   logic [SLOT_IDX_W-1:0]   cnt_ff;
   logic [SLOT_IDX_W-1:0]   cmp_idx_ff;
   logic                    cmp_en_ff;
   logic                    sel_found_ff;
   logic [SLOT_IDX_W-1:0]   sel_idx_ff;
   slot_type                sel_ff;
   logic [ID_W-1:0]         id_ctr_ff;
   logic [ID_W-1:0]         id_ctr_in;
   logic [TOTAL_W-1:0]      total_ff;
   logic [TOTAL_W-1:0]      total_in;
   logic                    rsp_valid_ff;
   status_type              rsp_status_ff;
   status_type              rsp_status_in;
   slot_type                rsp_slot_ff;
   slot_type                rsp_slot_in;
   logic [LIVE_W-1:0]       rsp_live_ff;

   cmp_type                 cmp;
   logic                    cmp_slot_valid;
   logic                    take;
   logic                    done;
   logic                    mem_we;
   slot_type                mem_wdata;
   slot_type                new_slot;

   // Shared compare unit sees the slot read in the previous cycle.
   wth_cmp_unit u_cmp (
      .req_i  (req_ff),
      .slot_i (rd_ff),
      .cmp_o  (cmp)
   );

   assign cmp_slot_valid = valid_ff[cmp_idx_ff];

   // Decide whether the slot under compare becomes the selected one.
   always_comb begin
      take = 1'b0;
      if (cmp_en_ff) begin
         case (req_ff.mode) inside
            MODE_CREATE: begin
               take = !cmp_slot_valid && !sel_found_ff;
            end
            MODE_DESTROY, MODE_MOVE, MODE_MARK, MODE_FIND: begin
               take = cmp_slot_valid && cmp.id_match && !sel_found_ff;
            end
            MODE_HIT: begin
               take = cmp_slot_valid && cmp.point_in;
            end
            default: begin
               take = 1'b0;
            end
         endcase
      end
   end

   // The write-back step finishes once the result register can take the transfer.
   assign done = (state_ff == S_WRITE) && (!rsp_valid_ff || !rsp_stall);

   // A new window sits at the origin with its commit mark clear.
   always_comb begin
      new_slot           = '0;
      new_slot.id        = id_ctr_ff;
      new_slot.pid       = req_ff.pid;
      new_slot.client    = req_ff.client;
      new_slot.w         = req_ff.w;
      new_slot.h         = req_ff.h;
   end

   // Table update and result for the selected slot.
   always_comb begin
      mem_we        = 1'b0;
      mem_wdata     = sel_ff;
      valid_in      = valid_ff;
      id_ctr_in     = id_ctr_ff;
      total_in      = total_ff;
      rsp_status_in = STATUS_MISS;
      rsp_slot_in   = '0;
      case (req_ff.mode) inside
         MODE_CREATE: begin
            if (sel_found_ff) begin
               mem_we               = 1'b1;
               mem_wdata            = new_slot;
               valid_in[sel_idx_ff] = 1'b1;
               id_ctr_in            = id_ctr_ff + 1'b1;
               total_in             = total_ff + 1'b1;
               rsp_status_in        = STATUS_OK;
               rsp_slot_in          = new_slot;
            end else begin
               rsp_status_in = STATUS_FULL;
            end
         end
         MODE_DESTROY: begin
            if (sel_found_ff) begin
               valid_in[sel_idx_ff] = 1'b0;
               total_in             = total_ff - 1'b1;
               rsp_status_in        = STATUS_OK;
               rsp_slot_in          = sel_ff;
            end
         end
         MODE_MOVE: begin
            mem_wdata.x = req_ff.x;
            mem_wdata.y = req_ff.y;
            if (sel_found_ff) begin
               mem_we        = 1'b1;
               rsp_status_in = STATUS_OK;
               rsp_slot_in   = mem_wdata;
            end
         end
         MODE_MARK: begin
            mem_wdata.committed = 1'b1;
            if (sel_found_ff) begin
               mem_we        = 1'b1;
               rsp_status_in = STATUS_OK;
               rsp_slot_in   = mem_wdata;
            end
         end
         MODE_FIND, MODE_HIT: begin
            if (sel_found_ff) begin
               rsp_status_in = STATUS_OK;
               rsp_slot_in   = sel_ff;
            end
         end
         default: begin
            rsp_status_in = STATUS_MISS;
         end
      endcase
      mem_we = mem_we && done;
   end

   // Slot memory: one write port for write-back, one registered read for the scan.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[sel_idx_ff] <= mem_wdata;
      end
      rd_ff <= mem[cnt_ff];
   end

   // Sequencer, table state and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         id_ctr_ff    <= ID_W'(1);
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         cmp_en_ff    <= 1'b0;
         sel_found_ff <= 1'b0;
      end else begin
         // A new result loaded this cycle takes precedence over the transfer of the old one.
         if (rsp_valid_ff && !rsp_stall && !done) begin
            rsp_valid_ff <= 1'b0;
         end
         cmp_en_ff  <= (state_ff == S_SCAN);
         cmp_idx_ff <= cnt_ff;
         if (take) begin
            sel_found_ff <= 1'b1;
            sel_idx_ff   <= cmp_idx_ff;
            sel_ff       <= rd_ff;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  req_ff.mode   <= req_mode;
                  req_ff.id     <= req_window_id;
                  req_ff.pid    <= req_owner_pid;
                  req_ff.client <= req_client_slot;
                  req_ff.x      <= req_pos_x;
                  req_ff.y      <= req_pos_y;
                  req_ff.w      <= req_size_w;
                  req_ff.h      <= req_size_h;
                  cnt_ff        <= '0;
                  sel_found_ff  <= 1'b0;
                  state_ff      <= S_SCAN;
               end
            end
            S_SCAN: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == LAST_IDX) begin
                  state_ff <= S_LAST;
               end
            end
            S_LAST: begin
               state_ff <= S_WRITE;
            end
            S_WRITE: begin
               if (done) begin
                  valid_ff      <= valid_in;
                  id_ctr_ff     <= id_ctr_in;
                  total_ff      <= total_in;
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= rsp_status_in;
                  rsp_slot_ff   <= rsp_slot_in;
                  rsp_live_ff   <= LIVE_W'(total_in);
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // Port drive.
   assign req_stall           = reset || (state_ff != S_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_found_id        = rsp_slot_ff.id;
   assign rsp_found_pid       = rsp_slot_ff.pid;
   assign rsp_found_client    = rsp_slot_ff.client;
   assign rsp_found_x         = rsp_slot_ff.x;
   assign rsp_found_y         = rsp_slot_ff.y;
   assign rsp_found_w         = rsp_slot_ff.w;
   assign rsp_found_h         = rsp_slot_ff.h;
   assign rsp_found_committed = rsp_slot_ff.committed;
   assign rsp_live_count      = rsp_live_ff;

   // The window count tracks the valid bits.
   `WTH_ASSERT_ALWAYS(a_total_matches_valid, clock, reset, TOTAL_W'($countones(valid_ff)) == total_ff)
   // The count never exceeds the table size.
   `WTH_ASSERT_ALWAYS(a_total_in_range, clock, reset, total_ff <= TOTAL_W'(SLOT_COUNT))
   // A table-full result is only given when every slot is taken.
   `WTH_ASSERT_IMPLY(a_full_means_full, clock, reset,
      rsp_valid_ff && (rsp_status_ff == STATUS_FULL), total_ff == TOTAL_W'(SLOT_COUNT))
   // A slot selected by id or by point is a live one.
   `WTH_ASSERT_IMPLY(a_selected_is_live, clock, reset,
      (state_ff == S_WRITE) && sel_found_ff && (req_ff.mode != MODE_CREATE),
      valid_ff[sel_idx_ff])

endmodule

`default_nettype wire

@@ test/window_table_hit_test_unit_test.sv @@
`timescale 1ns / 100ps

module window_table_hit_test_unit_test;
   import wth_pkg::*;

   // Codes six and seven select no operation.
   localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
   localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

   localparam int ITEMS_PER_PHASE = 225;
   localparam int DRAIN_CYCLES    = 40;
   localparam int QUIET_LIMIT     = 3000;

   // One result as the block should return it.
   typedef struct {
      status_type          status;
      slot_type            win;
      logic [LIVE_W-1:0]   live;
   } window_result_type;

   // One request of the directed table, with its result where it is typed in.
   typedef struct {
      req_type            stim;
      bit                 typed;
      window_result_type  want;
   } stim_row_type;

   logic clock;
   logic reset = 1'b1;

   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [MODE_W-1:0]         req_mode = '0;
   logic [ID_W-1:0]           req_window_id = '0;
   logic [PID_W-1:0]          req_owner_pid = '0;
   logic [CLIENT_W-1:0]       req_client_slot = '0;
   logic signed [POS_W-1:0]   req_pos_x = '0;
   logic signed [POS_W-1:0]   req_pos_y = '0;
   logic [SIZE_W-1:0]         req_size_w = '0;
   logic [SIZE_W-1:0]         req_size_h = '0;

   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [STATUS_W-1:0]       rsp_status;
   logic [ID_W-1:0]           rsp_found_id;
   logic [PID_W-1:0]          rsp_found_pid;
   logic [CLIENT_W-1:0]       rsp_found_client;
   logic signed [POS_W-1:0]   rsp_found_x;
   logic signed [POS_W-1:0]   rsp_found_y;
   logic [SIZE_W-1:0]         rsp_found_w;
   logic [SIZE_W-1:0]         rsp_found_h;
   logic                      rsp_found_committed;
   logic [LIVE_W-1:0]         rsp_live_count;

   // Shadow copy of the window table.
   bit                  slot_live [SLOT_COUNT];
   slot_type            slot_rec [SLOT_COUNT];
   logic [ID_W-1:0]     next_window_id;
   int                  windows_open;

   window_result_type   pending_results [$];
   int                  failures = 0;
   int                  results_seen = 0;
   int                  sender_idle_pct = 0;
   int                  receiver_stall_pct = 0;
   bit                  draining = 1'b0;
   logic [ID_W-1:0]     recent_gone_id = '0;

   window_table_hit_test_unit uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_mode            (req_mode),
      .req_window_id       (req_window_id),
      .req_owner_pid       (req_owner_pid),
      .req_client_slot     (req_client_slot),
      .req_pos_x           (req_pos_x),
      .req_pos_y           (req_pos_y),
      .req_size_w          (req_size_w),
      .req_size_h          (req_size_h),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_found_id        (rsp_found_id),
      .rsp_found_pid       (rsp_found_pid),
      .rsp_found_client    (rsp_found_client),
      .rsp_found_x         (rsp_found_x),
      .rsp_found_y         (rsp_found_y),
      .rsp_found_w         (rsp_found_w),
      .rsp_found_h         (rsp_found_h),
      .rsp_found_committed (rsp_found_committed),
      .rsp_live_count      (rsp_live_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Lowest valid slot that holds the id, or -1.
   function automatic int find_slot(input logic [ID_W-1:0] id);
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (slot_live[i] && slot_rec[i].id == id) begin
            return i;
         end
      end
      return -1;
   endfunction

   // Applies one request to the shadow table and returns the result it should give.
   function automatic window_result_type predict_table_op(input req_type r);
      window_result_type res;
      int idx;
      int px, py, wx, wy, ww, wh;
      res.status = STATUS_MISS;
      res.win = '0;
      idx = -1;
      case (r.mode)
         MODE_CREATE: begin
            for (int i = 0; i < SLOT_COUNT && idx < 0; i++) begin
               if (!slot_live[i]) idx = i;
            end
            if (idx < 0) begin
               res.status = STATUS_FULL;
            end else begin
               slot_live[idx] = 1'b1;
               slot_rec[idx] = '0;
               slot_rec[idx].id = next_window_id;
               slot_rec[idx].pid = r.pid;
               slot_rec[idx].client = r.client;
               slot_rec[idx].w = r.w;
               slot_rec[idx].h = r.h;
               next_window_id = next_window_id + 1'b1;
               windows_open++;
            end
         end
         MODE_DESTROY: begin
            idx = find_slot(r.id);
            // The fields are reported as they stood before the slot is freed.
            if (idx >= 0) begin
               res.status = STATUS_OK;
               res.win = slot_rec[idx];
               slot_live[idx] = 1'b0;
               windows_open--;
               idx = -1;
            end
         end
         MODE_MOVE: begin
            idx = find_slot(r.id);
            if (idx >= 0) begin
               slot_rec[idx].x = r.x;
               slot_rec[idx].y = r.y;
            end
         end
         MODE_MARK: begin
            idx = find_slot(r.id);
            if (idx >= 0) slot_rec[idx].committed = 1'b1;
         end
         MODE_FIND: begin
            idx = find_slot(r.id);
         end
         MODE_HIT: begin
            // Widened signed compare; the last containing slot wins.
            px = $signed(r.x);
            py = $signed(r.y);
            for (int i = 0; i < SLOT_COUNT; i++) begin
               if (slot_live[i]) begin
                  wx = $signed(slot_rec[i].x);
                  wy = $signed(slot_rec[i].y);
                  ww = slot_rec[i].w;
                  wh = slot_rec[i].h;
                  if (px >= wx && px < wx + ww && py >= wy && py < wy + wh) idx = i;
               end
            end
         end
         default: begin
         end
      endcase
      if (idx >= 0) begin
         res.status = STATUS_OK;
         res.win = slot_rec[idx];
      end
      res.live = windows_open[LIVE_W-1:0];
      return res;
   endfunction

   function automatic stim_row_type plain_row(input logic [MODE_W-1:0] mode,
                                              input logic [ID_W-1:0] id,
                                              input logic [PID_W-1:0] pid,
                                              input logic [CLIENT_W-1:0] client,
                                              input logic [POS_W-1:0] x,
                                              input logic [POS_W-1:0] y,
                                              input logic [SIZE_W-1:0] w,
                                              input logic [SIZE_W-1:0] h);
      stim_row_type row;
      row.stim.mode = mode;
      row.stim.id = id;
      row.stim.pid = pid;
      row.stim.client = client;
      row.stim.x = x;
      row.stim.y = y;
      row.stim.w = w;
      row.stim.h = h;
      row.typed = 1'b0;
      row.want.status = STATUS_MISS;
      row.want.win = '0;
      row.want.live = '0;
      return row;
   endfunction

   function automatic stim_row_type typed_row(input stim_row_type row,
                                              input status_type status,
                                              input slot_type win, input int live);
      stim_row_type out;
      out = row;
      out.typed = 1'b1;
      out.want.status = status;
      out.want.win = win;
      out.want.live = live[LIVE_W-1:0];
      return out;
   endfunction

   // Small offsets or random values, with the extremes now and then.
   function automatic logic [POS_W-1:0] random_pos();
      int roll, v;
      roll = $urandom_range(99);
      if (roll < 5) return 16'h8000;
      if (roll < 10) return 16'h7fff;
      if (roll < 50) begin
         v = $urandom_range(200);
         v = v - 100;
         return v[POS_W-1:0];
      end
      v = $urandom();
      return v[POS_W-1:0];
   endfunction

   function automatic logic [SIZE_W-1:0] random_size();
      int roll, v;
      roll = $urandom_range(99);
      if (roll < 8) return '0;
      if (roll < 16) return '1;
      if (roll < 50) return SIZE_W'($urandom_range(64, 1));
      v = $urandom();
      return v[SIZE_W-1:0];
   endfunction

   // Offset into or just outside a window of the given extent, with its edges favored.
   function automatic int edge_offset(input logic [SIZE_W-1:0] extent);
      int span;
      span = extent;
      case ($urandom_range(4))
         0: return -1;
         1: return 0;
         2: return span - 1;
         3: return span;
         default: return $urandom_range(span);
      endcase
   endfunction

   // Random request shaped by the shadow table: ids mostly of live windows,
   // hit points mostly on or around a live window.
   function automatic req_type random_request();
      req_type r;
      int roll, k, create_end, destroy_end, spot;
      int open_slots [$];
      logic [31:0] rnd;
      rnd = $urandom();
      r.id = rnd;
      rnd = $urandom();
      r.pid = rnd[PID_W-1:0];
      r.client = rnd[PID_W +: CLIENT_W];
      r.x = random_pos();
      r.y = random_pos();
      r.w = random_size();
      r.h = random_size();

      // Fill the table until it is full, then empty it most of the way.
      if (windows_open == SLOT_COUNT) draining = 1'b1;
      else if (windows_open <= 2) draining = 1'b0;
      create_end = draining ? 12 : 32;
      destroy_end = create_end + (draining ? 30 : 12);
      roll = $urandom_range(99);
      if (roll < 4) r.mode = MODE_W'($urandom_range(MODE_SPARE_HI));
      else if (roll < create_end) r.mode = MODE_CREATE;
      else if (roll < destroy_end) r.mode = MODE_DESTROY;
      else if (roll < 58) r.mode = MODE_MOVE;
      else if (roll < 68) r.mode = MODE_MARK;
      else if (roll < 78) r.mode = MODE_FIND;
      else r.mode = MODE_HIT;

      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (slot_live[i]) open_slots.push_back(i);
      end
      k = (open_slots.size() == 0) ? -1 : open_slots[$urandom_range(open_slots.size() - 1)];

      if (r.mode == MODE_HIT) begin
         if (k >= 0 && $urandom_range(99) < 75) begin
            spot = $signed(slot_rec[k].x) + edge_offset(slot_rec[k].w);
            r.x = spot[POS_W-1:0];
            spot = $signed(slot_rec[k].y) + edge_offset(slot_rec[k].h);
            r.y = spot[POS_W-1:0];
         end
      end else if (r.mode != MODE_CREATE) begin
         roll = $urandom_range(99);
         if (k >= 0 && roll < 85) r.id = slot_rec[k].id;
         else if (roll < 92) r.id = recent_gone_id;
      end
      if (r.mode == MODE_DESTROY) recent_gone_id = r.id;
      return r;
   endfunction

   // Drives one request until its transfer, then files the result it should give.
   task automatic issue(input stim_row_type row);
      window_result_type res;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= row.stim.mode;
      req_window_id <= row.stim.id;
      req_owner_pid <= row.stim.pid;
      req_client_slot <= row.stim.client;
      req_pos_x <= row.stim.x;
      req_pos_y <= row.stim.y;
      req_size_w <= row.stim.w;
      req_size_h <= row.stim.h;
      do @(posedge clock); while (req_stall);
      res = predict_table_op(row.stim);
      pending_results.push_back(row.typed ? row.want : res);
   endtask

   task automatic note_failure(input string msg);
      failures++;
      $display("ERROR: %s", msg);
   endtask

   task automatic compare_field(input string name, input logic [63:0] got,
                                input logic [63:0] want);
      if (got !== want) begin
         note_failure($sformatf("result %0d, %s: got %0h, expected %0h",
                                results_seen, name, got, want));
      end
   endtask

   // Result side: check each transfer and stall at random.
   always @(posedge clock) begin : result_check
      window_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (pending_results.size() == 0) begin
               note_failure($sformatf("result %0d arrived with nothing expected",
                                      results_seen));
            end else begin
               want = pending_results.pop_front();
               compare_field("status", rsp_status, want.status);
               compare_field("found_id", rsp_found_id, want.win.id);
               compare_field("found_pid", rsp_found_pid, want.win.pid);
               compare_field("found_client", rsp_found_client, want.win.client);
               compare_field("found_x", rsp_found_x, want.win.x);
               compare_field("found_y", rsp_found_y, want.win.y);
               compare_field("found_w", rsp_found_w, want.win.w);
               compare_field("found_h", rsp_found_h, want.win.h);
               compare_field("found_committed", rsp_found_committed, want.win.committed);
               compare_field("live_count", rsp_live_count, want.live);
            end
         end
         rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
      end
   end

   // Ends the run when neither channel has had a transfer for too long.
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("window_table_hit_test_unit test failed");
      $finish;
   end

   initial begin : stimulus
      stim_row_type directed_rows [$];
      slot_type top_win, bottom_win;
      req_type rand_req;
      int n;
      slot_live = '{default: 1'b0};
      slot_rec = '{default: '0};
      next_window_id = 1;
      windows_open = 0;
      sender_idle_pct = 30;
      receiver_stall_pct = 70;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      top_win = '0;
      top_win.id = 32'd1;
      top_win.pid = '1;
      top_win.client = '1;
      top_win.w = '1;
      top_win.h = '1;
      bottom_win = '0;
      bottom_win.id = 32'd2;

      // Empty table: nothing to find, and an unused code acts on nothing.
      directed_rows.push_back(typed_row(plain_row(MODE_FIND, '1, '0, '0, '0, '0, '0, '0),
                                        STATUS_MISS, '0, 0));
      directed_rows.push_back(typed_row(plain_row(MODE_SPARE_HI, '1, '1, '1, '1, '1, '1, '1),
                                        STATUS_MISS, '0, 0));
      // Creates with pid, client and size at their top and then at their bottom, then a miss.
      directed_rows.push_back(typed_row(plain_row(MODE_CREATE, '0, '1, '1, 16'h8000, 16'h7fff,
                                                  '1, '1), STATUS_OK, top_win, 1));
      directed_rows.push_back(typed_row(plain_row(MODE_CREATE, '1, '0, '0, '0, '0, '0, '0),
                                        STATUS_OK, bottom_win, 2));
      directed_rows.push_back(typed_row(plain_row(MODE_DESTROY, '0, '0, '0, '0, '0, '0, '0),
                                        STATUS_MISS, '0, 2));
      // Commit mark, then hit tests at both ends of the position range.
      directed_rows.push_back(plain_row(MODE_MARK, 32'd1, '0, '0, '0, '0, '0, '0));
      directed_rows.push_back(plain_row(MODE_MOVE, 32'd1, '0, '0, 16'h8000, 16'h8000, '0, '0));
      directed_rows.push_back(plain_row(MODE_HIT, '0, '0, '0, 16'hfffe, 16'hfffe, '0, '0));
      directed_rows.push_back(plain_row(MODE_HIT, '0, '0, '0, 16'hffff, 16'hffff, '0, '0));
      directed_rows.push_back(plain_row(MODE_MOVE, 32'd1, '0, '0, 16'h7fff, 16'h7fff, '0, '0));
      directed_rows.push_back(plain_row(MODE_HIT, '0, '0, '0, 16'h7fff, 16'h7fff, '0, '0));
      directed_rows.push_back(plain_row(MODE_FIND, 32'd2, '0, '0, '0, '0, '0, '0));
      // Fill every slot, then one create too many.
      for (n = 0; n < SLOT_COUNT - 2; n++) begin
         directed_rows.push_back(plain_row(MODE_CREATE, '0, PID_W'(n * 4099 + 7),
                                           CLIENT_W'(n + 1), '0, '0, SIZE_W'(n + 1),
                                           SIZE_W'(2 * n + 3)));
      end
      directed_rows.push_back(typed_row(plain_row(MODE_CREATE, '0, '1, '1, '0, '0, '1, '1),
                                        STATUS_FULL, '0, SLOT_COUNT));

      for (n = 0; n < directed_rows.size(); n++) issue(directed_rows[n]);

      // Random traffic in three idling regimes; each one starts from a quiet block.
      for (int phase = 0; phase < 3; phase++) begin
         sender_idle_pct = (phase == 0) ? 30 : (phase == 1) ? 70 : 0;
         receiver_stall_pct = (phase == 0) ? 70 : (phase == 1) ? 30 : 0;
         req_valid <= 1'b0;
         do @(posedge clock); while (pending_results.size() != 0);
         repeat (ITEMS_PER_PHASE) begin
            rand_req = random_request();
            issue(plain_row(rand_req.mode, rand_req.id, rand_req.pid, rand_req.client,
                            rand_req.x, rand_req.y, rand_req.w, rand_req.h));
         end
      end

      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("window_table_hit_test_unit test passed");
      end else begin
         $display("window_table_hit_test_unit test failed");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/wth_pkg.sv
rtl/core/wth_cmp_unit.sv
rtl/core/window_table_hit_test_unit.sv
test/window_table_hit_test_unit_test.sv
